/* hw/rtl/base64_line_encoder_unit_assert.svh */
// Assertion macros used by the encoder back end RTL.
`ifndef BASE64_LINE_ENCODER_UNIT_ASSERT_SVH
`define BASE64_LINE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B64LE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define B64LE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/b64le_pkg.sv */
package b64le_pkg;

   localparam int QueueDepth = 2;

   localparam logic [7:0] LineLengthReset = 8'd76;
   localparam logic [3:0] LineIndentReset = 4'd0;
   localparam logic [3:0] MaxIndent       = 4'd14;

   // register indexes on the csr port
   localparam logic CsrLineLength = 1'b0;
   localparam logic CsrLineIndent = 1'b1;

   localparam logic [5:0] SymMask     = 6'h3f;
   localparam logic [7:0] CharPad     = 8'h3d;
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharPlus    = 8'h2b;
   localparam logic [7:0] CharSlash   = 8'h2f;

   typedef struct packed {
      logic       is_pad;
      logic [5:0] sym;
   } slot_type;

   // one classified input byte: up to four encoded characters
   typedef struct packed {
      slot_type [3:0] slot;
      logic [1:0]     last_slot;
      logic           msg_end;
   } job_type;

   typedef struct packed {
      logic [7:0] line_length;
      logic [3:0] line_indent;
   } cfg_type;

   function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = CharPlus;
      end else begin
         r = CharSlash;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/b64le_front.sv */
// Byte intake: tracks the 3-byte group phase and splits bytes into symbols.
module b64le_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_data_byte,
   input  logic                req_message_end,
   output logic                req_stall,
   input  logic                queue_full,
   output logic                push,
   output b64le_pkg::job_type  push_job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   b64le_pkg::slot_type pad_slot;
   logic [7:0] b;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign b         = req_data_byte;

   always_comb begin
      pad_slot.is_pad = 1'b1;
      pad_slot.sym    = 6'd0;
      for (int i = 0; i < 4; i++) begin
         push_job.slot[i] = pad_slot;
      end
      push_job.msg_end = req_message_end;
      case (phase_ff)
         2'd1: begin
            push_job.slot[0] = '{is_pad: 1'b0, sym: {left_ff[1:0], b[7:4]}};
            push_job.slot[1] = '{is_pad: 1'b0, sym: {b[3:0], 2'b00}};
            push_job.last_slot = req_message_end ? 2'd2 : 2'd0;
            phase_in = 2'd2;
            left_in  = b[3:0];
         end
         2'd2: begin
            push_job.slot[0] = '{is_pad: 1'b0, sym: {left_ff, b[7:6]}};
            push_job.slot[1] = '{is_pad: 1'b0, sym: b[5:0] & b64le_pkg::SymMask};
            push_job.last_slot = 2'd1;
            phase_in = 2'd0;
            left_in  = 4'd0;
         end
         default: begin
            // phase three never occurs; handled as phase zero
            push_job.slot[0] = '{is_pad: 1'b0, sym: b[7:2]};
            push_job.slot[1] = '{is_pad: 1'b0, sym: {b[1:0], 4'b0000}};
            push_job.last_slot = req_message_end ? 2'd3 : 2'd0;
            phase_in = 2'd1;
            left_in  = {2'b00, b[1:0]};
         end
      endcase
      if (req_message_end) begin
         phase_in = 2'd0;
         left_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

/* hw/rtl/b64le_queue.sv */
// Small job queue between intake and character output.
module b64le_queue #(
   parameter int DEPTH = b64le_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64le_pkg::job_type  push_job,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output b64le_pkg::job_type  head_job
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   b64le_pkg::job_type entries_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

/* hw/rtl/b64le_back.sv */
`include "base64_line_encoder_unit_assert.svh"

// Character sequencer: indent, symbols, line wraps and closing newline.
module b64le_back (
   input  logic                clock,
   input  logic                reset,
   input  b64le_pkg::cfg_type  cfg,
   input  logic                head_valid,
   input  b64le_pkg::job_type  head_job,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_run_last,
   output logic                rsp_encoded_end
);

   typedef enum logic [1:0] {
      M_CHAR,
      M_WRAP,
      M_CLOSE
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [1:0] k_ff, k_in;
   logic [3:0] spaces_ff, spaces_in;
   logic [7:0] column_ff, column_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff;

   logic       fire;
   logic       final_char;
   logic [3:0] indent;
   logic [7:0] sym_char;
   logic [7:0] new_col;
   b64le_pkg::slot_type cur;

   assign fire       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign cur        = head_job.slot[k_ff];
   assign final_char = (k_ff == head_job.last_slot);
   assign indent     = (cfg.line_indent > b64le_pkg::MaxIndent) ?
                       b64le_pkg::MaxIndent : cfg.line_indent;
   assign sym_char   = cur.is_pad ? b64le_pkg::CharPad : b64le_pkg::sym_to_ascii(cur.sym);
   assign new_col    = column_ff + 8'd1;

   always_comb begin
      mode_in     = mode_ff;
      k_in        = k_ff;
      spaces_in   = spaces_ff;
      column_in   = column_ff;
      char_in     = char_ff;
      run_last_in = 1'b0;
      pop         = 1'b0;
      case (mode_ff)
         M_CHAR: begin
            if (column_ff == 8'd0 && spaces_ff < indent) begin
               char_in   = b64le_pkg::CharSpace;
               spaces_in = spaces_ff + 4'd1;
            end else begin
               char_in   = sym_char;
               spaces_in = 4'd0;
               if (new_col == cfg.line_length) begin
                  column_in = 8'd0;
                  mode_in   = M_WRAP;
               end else begin
                  column_in = new_col;
                  if (final_char) begin
                     if (head_job.msg_end && new_col != 8'd0) begin
                        mode_in = M_CLOSE;
                     end else begin
                        run_last_in = 1'b1;
                        pop         = 1'b1;
                        k_in        = 2'd0;
                     end
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
            end
         end
         M_WRAP: begin
            char_in = b64le_pkg::CharNewline;
            mode_in = M_CHAR;
            if (final_char) begin
               run_last_in = 1'b1;
               pop         = 1'b1;
               k_in        = 2'd0;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         M_CLOSE: begin
            char_in     = b64le_pkg::CharNewline;
            column_in   = 8'd0;
            mode_in     = M_CHAR;
            run_last_in = 1'b1;
            pop         = 1'b1;
            k_in        = 2'd0;
         end
         default: begin
            mode_in = M_CHAR;
         end
      endcase
      if (!fire) begin
         pop = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_CHAR;
         k_ff         <= 2'd0;
         spaces_ff    <= 4'd0;
         column_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            mode_ff   <= mode_in;
            k_ff      <= k_in;
            spaces_ff <= spaces_in;
            column_ff <= column_in;
         end
      end
      if (fire) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         end_ff      <= run_last_in && head_job.msg_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_encoded_end = end_ff;

   `B64LE_ASSERT_NOW(a_close_col, clock, reset, mode_ff == M_CLOSE, column_ff != 8'd0)
   `B64LE_ASSERT_NOW(a_wrap_col, clock, reset, mode_ff == M_WRAP, column_ff == 8'd0)
   `B64LE_ASSERT_NOW(a_spaces_max, clock, reset, 1'b1, spaces_ff <= b64le_pkg::MaxIndent)
   `B64LE_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid_ff && end_ff, run_last_ff)
   `B64LE_ASSERT_NEXT(a_close_done, clock, reset, fire && mode_ff == M_CLOSE, mode_ff == M_CHAR)

endmodule

/* hw/rtl/base64_line_encoder_unit.sv */
// Channel | Dir | Handshake                 | Payload
// req     | in  | req_valid / req_stall     | req_data_byte[7:0], req_message_end
// rsp     | out | rsp_valid / rsp_stall     | rsp_out_char[7:0], rsp_run_last, rsp_encoded_end
// csr     | in  | csr_write_enable          | csr_index, csr_write_data[7:0]
//
// One output character per cycle from the back sequencer while a job is queued and
// rsp_stall does not hold the output; a byte yields 1 to 4 symbols plus indent spaces and newlines.
// Intake takes one byte per cycle while the job queue has room.
// Synchronous active-high reset; no clearing pass, ready once reset is released.
// rsp_stall holds the output register; intake continues until the queue fills.
module base64_line_encoder_unit #(
   parameter int QUEUE_DEPTH = b64le_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   // input transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_message_end,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_encoded_end,
   // register writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   // configuration registers
   logic [7:0] line_length_ff;
   logic [3:0] line_indent_ff;
   b64le_pkg::cfg_type cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= b64le_pkg::LineLengthReset;
         line_indent_ff <= b64le_pkg::LineIndentReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            b64le_pkg::CsrLineLength: line_length_ff <= csr_write_data;
            b64le_pkg::CsrLineIndent: line_indent_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   assign cfg.line_length = line_length_ff;
   assign cfg.line_indent = line_indent_ff;

   // front -> queue -> back
   logic               push, pop, queue_full, head_valid;
   b64le_pkg::job_type push_job, head_job;

   b64le_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .req_stall       (req_stall),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   b64le_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // column tracking and line formatting live in the back end
   b64le_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_encoded_end (rsp_encoded_end)
   );

endmodule

/* test/base64_line_encoder_unit_test.sv */
`timescale 1ns / 1ps

// One expected character on the result channel
typedef struct packed {
   logic [7:0] out_char;
   logic       run_last;
   logic       encoded_end;
} b64_char_type;

// Tracks the encoder state and the characters still owed by the block
class b64_text_predictor;
   logic [7:0] line_length = b64le_pkg::LineLengthReset;
   logic [3:0] line_indent = b64le_pkg::LineIndentReset;
   logic [1:0] byte_phase  = 2'd0;
   logic [3:0] leftover    = 4'd0;
   logic [7:0] column      = 8'd0;
   string      alphabet    =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   b64_char_type expected_chars[$];
   b64_char_type step_chars[$];
   int         errors         = 0;
   int         bytes_taken    = 0;
   int         messages_taken = 0;
   int         chars_matched  = 0;

   function void write_reg(logic idx, logic [7:0] data);
      if (idx == b64le_pkg::CsrLineLength) begin
         line_length = data;
      end else begin
         line_indent = data[3:0];
      end
   endfunction

   function void put_raw(logic [7:0] c);
      b64_char_type rec;
      rec = '{out_char: c, run_last: 1'b0, encoded_end: 1'b0};
      step_chars.push_back(rec);
   endfunction

   // symbol plus indent at line start and newline at line end
   function void put_char(logic [7:0] c);
      logic [3:0] spaces;
      if (column == 8'd0) begin
         spaces = (line_indent > b64le_pkg::MaxIndent) ? b64le_pkg::MaxIndent : line_indent;
         for (int i = 0; i < spaces; i++) begin
            put_raw(b64le_pkg::CharSpace);
         end
      end
      put_raw(c);
      column = column + 8'd1;   // 8-bit wrap: length 0 means 256
      if (column == line_length) begin
         put_raw(b64le_pkg::CharNewline);
         column = 8'd0;
      end
   endfunction

   function void put_sym(logic [5:0] v);
      put_char(8'(alphabet[int'(v & b64le_pkg::SymMask)]));
   endfunction

   // note one accepted input transaction
   function void take_byte(logic [7:0] b, logic msg_end);
      b64_char_type last_rec;
      step_chars.delete();
      case (byte_phase)
         2'd1: begin
            put_sym({leftover[1:0], b[7:4]});
            leftover   = b[3:0];
            byte_phase = 2'd2;
            if (msg_end) begin
               put_sym({b[3:0], 2'b00});
               put_char(b64le_pkg::CharPad);
            end
         end
         2'd2: begin
            put_sym({leftover, b[7:6]});
            put_sym(b[5:0]);
            leftover   = 4'd0;
            byte_phase = 2'd0;
         end
         default: begin
            put_sym(b[7:2]);
            leftover   = {2'b00, b[1:0]};
            byte_phase = 2'd1;
            if (msg_end) begin
               put_sym({b[1:0], 4'b0000});
               put_char(b64le_pkg::CharPad);
               put_char(b64le_pkg::CharPad);
            end
         end
      endcase
      if (msg_end) begin
         if (column != 8'd0) begin
            put_raw(b64le_pkg::CharNewline);
            column = 8'd0;
         end
         byte_phase = 2'd0;
         leftover   = 4'd0;
         messages_taken++;
      end
      last_rec = step_chars.pop_back();
      last_rec.run_last    = 1'b1;
      last_rec.encoded_end = msg_end;
      step_chars.push_back(last_rec);
      foreach (step_chars[i]) begin
         expected_chars.push_back(step_chars[i]);
      end
      bytes_taken++;
   endfunction

   // compare one accepted result transaction with the oldest expectation
   function void match_char(logic [7:0] c, logic rl, logic ee);
      b64_char_type want;
      if (expected_chars.size() == 0) begin
         $error("unexpected result: out_char %h run_last %b encoded_end %b", c, rl, ee);
         errors++;
         return;
      end
      want = expected_chars.pop_front();
      chars_matched++;
      if (c !== want.out_char) begin
         $error("out_char: expected %h, actual %h", want.out_char, c);
         errors++;
      end
      if (rl !== want.run_last) begin
         $error("run_last: expected %b, actual %b", want.run_last, rl);
         errors++;
      end
      if (ee !== want.encoded_end) begin
         $error("encoded_end: expected %b, actual %b", want.encoded_end, ee);
         errors++;
      end
   endfunction

   function int pending();
      return expected_chars.size();
   endfunction
endclass

module base64_line_encoder_unit_test;
   // long receiver hold-off, in cycles, used to back the block up
   localparam int LongHold      = 150;
   // settle margin after the last owed character has come out
   localparam int SettleCycles  = 8;
   // cycles with no transaction on either channel before giving up
   localparam int WatchdogLimit = 2000;
   // random bytes per idling phase
   localparam int RandomItems   = 25;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte    = 8'h00;
   logic       req_message_end  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_encoded_end;
   logic       csr_write_enable = 1'b0;
   logic       csr_index        = b64le_pkg::CsrLineLength;
   logic [7:0] csr_write_data   = 8'h00;

   // idle percentages, changed per phase by the stimulus
   int send_idle_pct = 19;
   int recv_idle_pct = 75;
   // set by the stimulus, picked up and cleared by the receiver
   bit hold_off_req  = 1'b0;
   int quiet_cycles  = 0;

   b64_text_predictor expected_text;

   base64_line_encoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_encoded_end (rsp_encoded_end),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Monitor: everything sampled at the rising edge. The input transaction is
   // noted before the result check, so a same-edge pair is handled in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_text.take_byte(req_data_byte, req_message_end);
         end
         if (rsp_valid && !rsp_stall) begin
            expected_text.match_char(rsp_out_char, rsp_run_last, rsp_encoded_end);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("stalled: %0d cycles without a transaction", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Receiver: random stall each cycle, or one long hold-off on request.
   // The hold-off is counted here so the sender keeps offering bytes meanwhile.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // One input transaction. Returns at the edge that accepted it, with valid
   // still high, so the next call can follow back to back.
   task automatic send_byte(input logic [7:0] data_byte, input logic msg_end);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data_byte;
      req_message_end <= msg_end;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(input logic [7:0] bytes[$]);
      foreach (bytes[i]) begin
         send_byte(bytes[i], i == bytes.size() - 1);
      end
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // Sender goes quiet until every owed character has come out, then settles.
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_text.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Register write; only called while the block is drained.
   task automatic write_csr(input logic idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      expected_text.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random messages, mostly short, some longer; drained once halfway through and at the end.
   task automatic run_traffic(input int n_items);
      int sent   = 0;
      int len    = 0;
      bit paused = 1'b0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         send_message(len);
         sent += len;
         if (!paused && sent >= n_items / 2) begin
            pause_until_drained();
            paused = 1'b1;
         end
      end
      pause_until_drained();
   endtask

   initial begin
      expected_text = new;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset config (76 chars, no indent): one-byte message with
      // double pad, two-byte message with single pad, full groups hitting
      // the '+' and '/' symbols, all-zero and all-one bytes.
      send_text('{8'h00});
      send_text('{8'hFF});
      send_text('{8'hFF, 8'h00});
      send_text('{8'hFB, 8'hEF, 8'hBE});
      send_text('{8'hFF, 8'hFF, 8'hFF});
      pause_until_drained();

      // short lines with indent; upper data bits of the indent write ignored
      write_csr(b64le_pkg::CsrLineLength, 8'd4);
      write_csr(b64le_pkg::CsrLineIndent, 8'hF2);
      send_text('{8'h4D, 8'h61, 8'h6E, 8'h00, 8'h10});
      pause_until_drained();

      // one char per line, indent fifteen saturates to fourteen
      write_csr(b64le_pkg::CsrLineLength, 8'd1);
      write_csr(b64le_pkg::CsrLineIndent, 8'h0F);
      send_text('{8'h80});
      send_text('{8'h7F, 8'h01});
      pause_until_drained();

      // Phase A: sender idles lightly, receiver heavily. Starts with a long
      // receiver hold-off so the job queue fills and req_stall rises.
      write_csr(b64le_pkg::CsrLineLength, 8'($urandom_range(2, 12)));
      write_csr(b64le_pkg::CsrLineIndent, 8'($urandom_range(255)));
      hold_off_req = 1'b1;
      send_message(24);
      run_traffic(RandomItems);

      // Phase B: roles swapped; line length 255, deepest legal indent
      send_idle_pct = 75;
      recv_idle_pct = 19;
      write_csr(b64le_pkg::CsrLineLength, 8'd255);
      write_csr(b64le_pkg::CsrLineIndent, 8'd14);
      run_traffic(RandomItems);

      // Phase C: no idling; length zero means 256 per line, so a longer
      // message runs past the Phase A lengths without a break
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(b64le_pkg::CsrLineLength, 8'd0);
      write_csr(b64le_pkg::CsrLineIndent, 8'($urandom_range(15)));
      send_message(30);
      run_traffic(RandomItems);

      $display("Encoded %0d bytes in %0d messages, %0d characters checked;",
               expected_text.bytes_taken, expected_text.messages_taken,
               expected_text.chars_matched);
      $display("line lengths 1 to 255 and length zero, indents 0 to 15, three idle mixes.");
      if (expected_text.errors == 0 && expected_text.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/b64le_pkg.sv
hw/rtl/b64le_front.sv
hw/rtl/b64le_queue.sv
hw/rtl/b64le_back.sv
hw/rtl/base64_line_encoder_unit.sv
test/base64_line_encoder_unit_test.sv
